/* src/tslc_pkg.sv */
// Shared constants and the CRC-8 byte step for the timed sample logger.
package tslc_pkg;

    localparam int BUFFER_DEPTH = 12;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam int REC_BYTES    = 7;
    localparam int REC_W        = 64;

    localparam logic [7:0]  CRC_POLY   = 8'h07;
    localparam logic [7:0]  CRC_TOPBIT = 8'h80;
    localparam logic [7:0]  FLAG_VALID = 8'h01;

    localparam logic [31:0] SAMPLE_INTERVAL_RST  = 32'd300;
    localparam logic [31:0] FLUSH_INTERVAL_RST   = 32'd3600;
    localparam logic [31:0] MIN_TRUSTED_TIME_RST = 32'd1000000;

    localparam logic [1:0] REG_SAMPLE_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_FLUSH_INTERVAL   = 2'd1;
    localparam logic [1:0] REG_MIN_TRUSTED_TIME = 2'd2;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOPBIT) != 8'h00)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* src/timed_sample_logger_crc8_top.sv */
// Timed sample logger: interval checks, CRC-8 record packing, buffer memory and flush drain.
// An accepted event passes ST_EVAL and then ST_FLCHK (ST_EVAL alone when its time is untrusted);
// a stored sample adds ST_CRC (one CRC byte per cycle over 7 bytes) and then the memory write.
// A new event is taken only in ST_IDLE, once the last one is through; a flush reads each record
// through ST_READ and ST_LOAD, held by any output stall, from the single-port registered-read memory.
// Reset: rst_n clears intervals to their defaults, times and count to zero; the
// record memory is not cleared, only entries below the count are ever read.
module timed_sample_logger_crc8_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // now_epoch[31:0], temperature[47:32], reading_valid[48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // rec_epoch[31:0], rec_temp[47:32], rec_flags[55:48],
                                   // rec_crc[63:56]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_CRC   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_FLCHK = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_LOAD  = 3'd6;

    logic [2:0]  state_reg, state_next;

    logic [31:0] sample_interval_reg;
    logic [31:0] flush_interval_reg;
    logic [31:0] min_trusted_time_reg;

    logic [31:0] last_sample_reg, last_sample_next;
    logic [31:0] last_flush_reg, last_flush_next;
    logic [tslc_pkg::CNT_W-1:0] count_reg, count_next;

    logic [31:0] now_reg;
    logic [15:0] temp_reg;
    logic        valid_reg;

    logic        do_flush_reg, do_flush_next;
    logic [7:0]  crc_reg, crc_next;
    logic [2:0]  byte_idx_reg, byte_idx_next;
    logic [tslc_pkg::ADDR_W-1:0] rd_idx_reg, rd_idx_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic [tslc_pkg::REC_W-1:0] mem [tslc_pkg::BUFFER_DEPTH];
    logic [tslc_pkg::REC_W-1:0] rdata_reg;

    logic [55:0] rec56;
    logic [31:0] samp_diff, flush_diff;
    logic        samp_elapsed, flush_elapsed;
    logic        rec_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign rec56 = {(tslc_pkg::FLAG_VALID & {8{valid_reg}}), temp_reg, now_reg};

    // Signed difference: elapsed only when non-negative and at least the interval
    assign samp_diff     = now_reg - last_sample_reg;
    assign flush_diff    = now_reg - last_flush_reg;
    assign samp_elapsed  = !samp_diff[31] && (samp_diff >= sample_interval_reg);
    assign flush_elapsed = !flush_diff[31] && (flush_diff >= flush_interval_reg);
    assign rec_last      = ((tslc_pkg::CNT_W'(rd_idx_reg) + tslc_pkg::CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next       = state_reg;
        last_sample_next = last_sample_reg;
        last_flush_next  = last_flush_reg;
        count_next       = count_reg;
        do_flush_next    = do_flush_reg;
        crc_next         = crc_reg;
        byte_idx_next    = byte_idx_reg;
        rd_idx_next      = rd_idx_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (now_reg < min_trusted_time_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    do_flush_next = flush_elapsed;
                    state_next    = ST_FLCHK;
                    if (samp_elapsed)
                    begin
                        last_sample_next = now_reg;
                        // Drop the record when the buffer is full
                        if (count_reg < tslc_pkg::CNT_W'(tslc_pkg::BUFFER_DEPTH))
                        begin
                            crc_next      = 8'h00;
                            byte_idx_next = 3'd0;
                            state_next    = ST_CRC;
                        end
                    end
                end
            end
            ST_CRC:
            begin
                crc_next      = tslc_pkg::crc8_byte(crc_reg, rec56[byte_idx_reg*8 +: 8]);
                byte_idx_next = byte_idx_reg + 3'd1;
                if (byte_idx_reg == 3'(tslc_pkg::REC_BYTES - 1))
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                count_next = count_reg + tslc_pkg::CNT_W'(1);
                state_next = ST_FLCHK;
            end
            ST_FLCHK:
            begin
                if (do_flush_reg)
                begin
                    last_flush_next = now_reg;
                    rd_idx_next     = '0;
                    if (count_reg == '0)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = rdata_reg;
                    m_last_next  = rec_last;
                    if (rec_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + tslc_pkg::ADDR_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            sample_interval_reg  <= tslc_pkg::SAMPLE_INTERVAL_RST;
            flush_interval_reg   <= tslc_pkg::FLUSH_INTERVAL_RST;
            min_trusted_time_reg <= tslc_pkg::MIN_TRUSTED_TIME_RST;
            last_sample_reg      <= '0;
            last_flush_reg       <= '0;
            count_reg            <= '0;
            do_flush_reg         <= 1'b0;
            byte_idx_reg         <= '0;
            rd_idx_reg           <= '0;
            m_valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_sample_reg <= last_sample_next;
            last_flush_reg  <= last_flush_next;
            count_reg       <= count_next;
            do_flush_reg    <= do_flush_next;
            byte_idx_reg    <= byte_idx_next;
            rd_idx_reg      <= rd_idx_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tslc_pkg::REG_SAMPLE_INTERVAL:  sample_interval_reg  <= cfg_wdata;
                    tslc_pkg::REG_FLUSH_INTERVAL:   flush_interval_reg   <= cfg_wdata;
                    tslc_pkg::REG_MIN_TRUSTED_TIME: min_trusted_time_reg <= cfg_wdata;
                    default:                        ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        crc_reg    <= crc_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        if (s_tvalid && s_tready)
        begin
            now_reg   <= s_tdata[31:0];
            temp_reg  <= s_tdata[47:32];
            valid_reg <= s_tdata[48];
        end
    end

    // Record memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            mem[count_reg[tslc_pkg::ADDR_W-1:0]] <= {crc_reg, rec56};
        if (state_reg == ST_READ)
            rdata_reg <= mem[rd_idx_reg];
    end

endmodule

/* bench/tb_timed_sample_logger_crc8_top.sv */
// Self-checking testbench for the timed sample logger with CRC-8 record flush.
`timescale 1ns / 1ps

module tb_timed_sample_logger_crc8_top;

    localparam logic [1:0] REG_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         WATCHDOG_LIMIT = 3000;

    typedef struct packed
    {
        logic [31:0] epoch;
        logic [15:0] temp;
        logic [7:0]  flags;
        logic [7:0]  crc;
        logic        last;
    } flushed_rec_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // now_epoch[31:0], temperature[47:32], reading_valid[48]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;          // rec_epoch[31:0], rec_temp[47:32], rec_flags[55:48],
                                   // rec_crc[63:56]
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // Predicted block state
    logic [31:0]  sample_iv_q   = tslc_pkg::SAMPLE_INTERVAL_RST;
    logic [31:0]  flush_iv_q    = tslc_pkg::FLUSH_INTERVAL_RST;
    logic [31:0]  trust_floor_q = tslc_pkg::MIN_TRUSTED_TIME_RST;
    logic [31:0]  last_sample_q = '0;
    logic [31:0]  last_flush_q  = '0;
    flushed_rec_t stored_recs[tslc_pkg::BUFFER_DEPTH];
    int           stored_cnt_q  = 0;
    flushed_rec_t rec_queue[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    bit idle_on        = 1'b1;
    int hold_req       = 0;
    int hold_left      = 0;
    int stall_left     = 0;

    timed_sample_logger_crc8_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8)
            c = c[7] ? ({c[6:0], 1'b0} ^ tslc_pkg::CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    // Signed 32-bit difference; a negative one never reaches the interval.
    function automatic bit interval_passed(input logic [31:0] now, input logic [31:0] then,
                                           input logic [31:0] iv);
        logic [31:0] d;
        d = now - then;
        return !d[31] && (d >= iv);
    endfunction

    function automatic flushed_rec_t make_record(input logic [31:0] epoch,
                                                 input logic [15:0] temp, input logic vbit);
        flushed_rec_t r;
        logic [55:0]  body;
        r.epoch = epoch;
        r.temp  = temp;
        r.flags = vbit ? tslc_pkg::FLAG_VALID : 8'h00;
        r.last  = 1'b0;
        body    = {r.flags, temp, epoch};
        r.crc   = 8'h00;
        for (int i = 0; i < tslc_pkg::REC_BYTES; i++)
            r.crc = crc8_update(r.crc, body[8 * i +: 8]);
        return r;
    endfunction

    function automatic void predict_reading(input logic [31:0] epoch, input logic [15:0] temp,
                                            input logic vbit);
        flushed_rec_t r;
        if (epoch < trust_floor_q)
            return;
        if (interval_passed(epoch, last_sample_q, sample_iv_q))
        begin
            last_sample_q = epoch;
            if (stored_cnt_q < tslc_pkg::BUFFER_DEPTH)
            begin
                stored_recs[stored_cnt_q] = make_record(epoch, temp, vbit);
                stored_cnt_q++;
            end
        end
        if (interval_passed(epoch, last_flush_q, flush_iv_q))
        begin
            last_flush_q = epoch;
            for (int i = 0; i < stored_cnt_q; i++)
            begin
                r      = stored_recs[i];
                r.last = (i == stored_cnt_q - 1);
                rec_queue.push_back(r);
            end
            stored_cnt_q = 0;
        end
    endfunction

    // Later of the two stored times, read as signed distance
    function automatic logic [31:0] latest_stamp();
        logic [31:0] d;
        d = last_flush_q - last_sample_q;
        return d[31] ? last_sample_q : last_flush_q;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            tslc_pkg::REG_SAMPLE_INTERVAL:  sample_iv_q   = val;
            tslc_pkg::REG_FLUSH_INTERVAL:   flush_iv_q    = val;
            tslc_pkg::REG_MIN_TRUSTED_TIME: trust_floor_q = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_reading(input logic [31:0] epoch, input logic [15:0] temp,
                                input logic vbit);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, vbit, temp, epoch};
        do @(posedge clk); while (!s_tready);
        predict_reading(epoch, temp, vbit);
    endtask

    // Drop valid, wait for every expected record, then let the block go quiet.
    task automatic wait_settled();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rec_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    task automatic test_default_settings();
        send_reading(32'd999_999, 16'h1234, 1'b1);
        send_reading(32'd1_000_000, 16'h8000, 1'b1);
        send_reading(32'd1_000_299, 16'h0000, 1'b0);
        send_reading(32'd1_000_300, 16'h7FFF, 1'b0);
        send_reading(32'd1_000_000, 16'h0005, 1'b1);
        send_reading(32'd1_003_600, 16'hFFFF, 1'b1);
    endtask

    task automatic test_buffer_full();
        wait_settled();
        write_reg(tslc_pkg::REG_SAMPLE_INTERVAL, 32'd1);
        write_reg(tslc_pkg::REG_FLUSH_INTERVAL, 32'hFFFF_FFFF);
        write_reg(tslc_pkg::REG_MIN_TRUSTED_TIME, 32'd0);
        // overfill: the last two samples are dropped
        for (int k = 0; k < tslc_pkg::BUFFER_DEPTH + 2; k++)
            send_reading(32'd1_003_601 + k, 16'($urandom_range(0, 16'hFFFF)), k[0]);
        wait_settled();
        write_reg(tslc_pkg::REG_FLUSH_INTERVAL, 32'd1);
        send_reading(32'd1_003_700, 16'h4321, 1'b1);
    endtask

    task automatic test_time_extremes();
        send_reading(32'd1_003_700 + 32'h7FFF_FFFF, 16'h0001, 1'b0);
        send_reading(32'hFFFF_FFFF, 16'h8000, 1'b1);
        send_reading(32'h0000_0000, 16'h7FFF, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_settled();
        write_reg(tslc_pkg::REG_SAMPLE_INTERVAL, 32'hFFFF_FFFF);
        send_reading(32'd5, 16'h00FF, 1'b1);
        wait_settled();
        write_reg(REG_UNUSED, 32'd1);
        send_reading(32'd10, 16'hFF00, 1'b0);
        wait_settled();
        write_reg(tslc_pkg::REG_MIN_TRUSTED_TIME, 32'hFFFF_FFFF);
        send_reading(32'hFFFF_FFFE, 16'h5555, 1'b1);
    endtask

    task automatic test_output_stall();
        logic [31:0] t;
        wait_settled();
        t = latest_stamp() + 32'd100;
        write_reg(tslc_pkg::REG_SAMPLE_INTERVAL, 32'd1);
        write_reg(tslc_pkg::REG_FLUSH_INTERVAL, 32'd6);
        write_reg(tslc_pkg::REG_MIN_TRUSTED_TIME, t);
        hold_req = 300;
        for (int k = 0; k < 30; k++)
        begin
            t = t + 32'd1;
            send_reading(t, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_logging(input int n_items, input int iv_lo, input int iv_hi);
        logic [31:0] t;
        logic [31:0] s_iv;
        logic [31:0] floor;
        int          sent;
        int          pick;
        wait_settled();
        t     = latest_stamp() + $urandom_range(1, 1 << 20);
        s_iv  = $urandom_range(iv_lo, iv_hi);
        floor = (t > 32'd2000) ? t - $urandom_range(0, 2000) : 32'd0;
        write_reg(tslc_pkg::REG_SAMPLE_INTERVAL, s_iv);
        write_reg(tslc_pkg::REG_FLUSH_INTERVAL, s_iv * $urandom_range(1, 20));
        write_reg(tslc_pkg::REG_MIN_TRUSTED_TIME, floor);
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0 && floor != 0)
                send_reading($urandom_range(0, floor - 1), 16'($urandom_range(0, 16'hFFFF)),
                             1'($urandom_range(0, 1)));
            else if (pick == 1)
                send_reading(t - $urandom_range(1, 32'h7FFF_FFFF),
                             16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
            else
            begin
                t = t + $urandom_range(0, 2 * s_iv);
                send_reading(t, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_settings();
        test_buffer_full();
        test_time_extremes();
        test_register_extremes();
        test_output_stall();
        test_random_logging(64, 1, 4);
        test_random_logging(64, 1, 40);
        test_random_logging(64, 1000, 1_000_000);
        test_random_logging(64, 1, 20);
        wait_settled();
        idle_on = 1'b0;
        test_random_logging(64, 1, 10);
        wait_settled();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: long hold on request, random stall bursts otherwise
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_records
        flushed_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rec_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected record, expected none, actual %0h last %0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = rec_queue.pop_front();
                if (m_tdata[31:0] !== want.epoch)
                    report_mismatch("rec_epoch", want.epoch, m_tdata[31:0]);
                if (m_tdata[47:32] !== want.temp)
                    report_mismatch("rec_temp", want.temp, m_tdata[47:32]);
                if (m_tdata[55:48] !== want.flags)
                    report_mismatch("rec_flags", want.flags, m_tdata[55:48]);
                if (m_tdata[63:56] !== want.crc)
                    report_mismatch("rec_crc", want.crc, m_tdata[63:56]);
                if (m_tlast !== want.last)
                    report_mismatch("last", want.last, m_tlast);
            end
        end
    end

    // Stop the run when no transaction completes for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
